>>> hdl/rttip_pkg.sv
// Shared types, character codes and helper functions for the radix text parser.
`timescale 1ns / 1ps

package rttip_pkg;

   localparam int VALUE_W    = 64;
   localparam int CHAR_W     = 8;
   localparam int RADIX_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED = 2'd1;

   // Bases with special meaning
   localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_BIN  = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
   localparam logic [RADIX_W-1:0] NOT_DIGIT  = 6'd37;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LC_X   = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LC_O   = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_LC_B   = 8'h62;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;
   localparam logic [CHAR_W-1:0] DIGIT_OFS = 8'd10;

   typedef enum logic [3:0] {
      PH_LEAD,
      PH_LEAD2,
      PH_AUTO_ZERO,
      PH_ZERO_RUN,
      PH_ZERO_WS,
      PH_EXPL_ZERO,
      PH_PREFIX,
      PH_ZEROS,
      PH_DIGITS,
      PH_SPOOL,
      PH_DISCARD
   } phase_type;

   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic               signed_mode;
   } cfg_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] t;
      t = NOT_DIGIT;
      if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         t = c - CH_ZERO;
      end else if ((c >= CH_LC_A) && (c <= CH_LC_Z)) begin
         t = c - CH_LC_A + DIGIT_OFS;
      end else if ((c >= CH_UC_A) && (c <= CH_UC_Z)) begin
         t = c - CH_UC_A + DIGIT_OFS;
      end
      return t[RADIX_W-1:0];
   endfunction

   function automatic logic [CHAR_W-1:0] prefix_letter(input logic [RADIX_W-1:0] r);
      logic [CHAR_W-1:0] l;
      if (r == RADIX_HEX) begin
         l = CH_LC_X;
      end else if (r == RADIX_OCT) begin
         l = CH_LC_O;
      end else begin
         l = CH_LC_B;
      end
      return l;
   endfunction

endpackage

>>> hdl/rttip_parse_core.sv
// Per-string parse state and the single-pass character step with result shaping.
`timescale 1ns / 1ps

module rttip_parse_core #(
   parameter int WORD_BITS   = 64,
   parameter int OFFSET_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rttip_pkg::cfg_type                   cfg_i,
   input  logic [rttip_pkg::CHAR_W-1:0]         char_i,
   input  logic                                 last_i,
   input  logic                                 fire_i,
   output logic                                 emit_o,
   output logic [rttip_pkg::VALUE_W-1:0]        value_o,
   output logic                                 range_o,
   output logic [OFFSET_BITS-1:0]               offset_o
);

   localparam int W  = WORD_BITS;
   localparam int VW = rttip_pkg::VALUE_W;
   localparam int RW = rttip_pkg::RADIX_W;

   localparam logic [W-1:0] WORD_MASK = {W{1'b1}};
   localparam logic [W-1:0] LONG_MAX  = {1'b0, {(W-1){1'b1}}};

   rttip_pkg::phase_type    phase_ff, phase_in, ph;
   logic [W-1:0]            acc_ff, acc_in;
   logic [RW-1:0]           radix_ff, radix_in, ar;
   logic                    neg_ff, neg_in;
   logic                    ovf_ff, ovf_in;
   logic [OFFSET_BITS-1:0]  pos_ff, pos_in;

   logic [1:0]              adv;
   logic                    done;
   logic                    hit;
   logic                    sp;
   logic [RW-1:0]           d;
   logic [W+6:0]            mac;
   logic [OFFSET_BITS:0]    pos_sum;
   logic [W-1:0]            res_word;
   logic                    res_range;

   assign sp = rttip_pkg::is_space(char_i);
   assign d  = rttip_pkg::digit_of(char_i);

   // One pass over the character; phases are laid out in the order control flows forward
   always_comb begin
      ph     = phase_ff;
      ar     = radix_ff;
      acc_in = acc_ff;
      neg_in = neg_ff;
      ovf_in = ovf_ff;
      adv    = 2'd0;
      done   = 1'b0;
      hit    = 1'b0;
      mac    = '0;

      if (ph > rttip_pkg::PH_DISCARD) begin
         ph   = rttip_pkg::PH_DISCARD;
         done = 1'b1;
      end

      if (!done && ph == rttip_pkg::PH_LEAD) begin
         if (sp) begin
            adv  = adv + 2'd1;
            done = 1'b1;
         end else begin
            ph = rttip_pkg::PH_LEAD2;
            if (cfg_i.signed_mode &&
                (char_i == rttip_pkg::CH_PLUS || char_i == rttip_pkg::CH_MINUS)) begin
               neg_in = (char_i == rttip_pkg::CH_MINUS);
               adv    = adv + 2'd1;
               done   = 1'b1;
            end
         end
      end

      if (!done && ph == rttip_pkg::PH_LEAD2) begin
         if (sp) begin
            adv  = adv + 2'd1;
            done = 1'b1;
         end else if (cfg_i.radix == rttip_pkg::RADIX_AUTO) begin
            if (char_i == rttip_pkg::CH_ZERO) begin
               adv  = adv + 2'd1;
               ph   = rttip_pkg::PH_AUTO_ZERO;
               done = 1'b1;
            end else begin
               ar = rttip_pkg::RADIX_DEC;
               ph = rttip_pkg::PH_ZEROS;
            end
         end else if (cfg_i.radix < rttip_pkg::RADIX_MIN ||
                      cfg_i.radix > rttip_pkg::RADIX_MAX) begin
            hit  = 1'b1;
            done = 1'b1;
         end else begin
            ar = cfg_i.radix;
            if ((cfg_i.radix == rttip_pkg::RADIX_HEX || cfg_i.radix == rttip_pkg::RADIX_OCT ||
                 cfg_i.radix == rttip_pkg::RADIX_BIN) && char_i == rttip_pkg::CH_ZERO) begin
               adv  = adv + 2'd1;
               ph   = rttip_pkg::PH_EXPL_ZERO;
               done = 1'b1;
            end else begin
               ph = rttip_pkg::PH_ZEROS;
            end
         end
      end

      if (!done && ph == rttip_pkg::PH_AUTO_ZERO) begin
         if ((char_i | rttip_pkg::CASE_BIT) == rttip_pkg::CH_LC_X) begin
            ar   = rttip_pkg::RADIX_HEX;
            ph   = rttip_pkg::PH_PREFIX;
            done = 1'b1;
         end else if ((char_i | rttip_pkg::CASE_BIT) == rttip_pkg::CH_LC_O) begin
            ar   = rttip_pkg::RADIX_OCT;
            ph   = rttip_pkg::PH_PREFIX;
            done = 1'b1;
         end else if ((char_i | rttip_pkg::CASE_BIT) == rttip_pkg::CH_LC_B) begin
            ar   = rttip_pkg::RADIX_BIN;
            ph   = rttip_pkg::PH_PREFIX;
            done = 1'b1;
         end else begin
            ph = rttip_pkg::PH_ZERO_RUN;
         end
      end

      if (!done && ph == rttip_pkg::PH_ZERO_RUN) begin
         if (char_i == rttip_pkg::CH_ZERO) begin
            adv  = adv + 2'd1;
            done = 1'b1;
         end else begin
            ph = rttip_pkg::PH_ZERO_WS;
         end
      end

      if (!done && ph == rttip_pkg::PH_ZERO_WS) begin
         if (sp) begin
            adv = adv + 2'd1;
         end else begin
            hit = 1'b1;
         end
         done = 1'b1;
      end

      if (!done && ph == rttip_pkg::PH_EXPL_ZERO) begin
         if ((char_i | rttip_pkg::CASE_BIT) == rttip_pkg::prefix_letter(ar)) begin
            ph   = rttip_pkg::PH_PREFIX;
            done = 1'b1;
         end else begin
            ph = rttip_pkg::PH_ZEROS;
         end
      end

      // A digit right after a prefix is counted here and again below
      if (!done && ph == rttip_pkg::PH_PREFIX) begin
         if (d < ar) begin
            adv = adv + 2'd1;
            ph  = rttip_pkg::PH_ZEROS;
         end else begin
            hit  = 1'b1;
            done = 1'b1;
         end
      end

      if (!done && ph == rttip_pkg::PH_ZEROS) begin
         if (char_i == rttip_pkg::CH_ZERO) begin
            adv  = adv + 2'd1;
            done = 1'b1;
         end else begin
            ph = rttip_pkg::PH_DIGITS;
         end
      end

      if (!done && ph == rttip_pkg::PH_DIGITS) begin
         if (d >= ar) begin
            hit = 1'b1;
         end else begin
            mac = ({7'b0, acc_ff} * {{(W+1){1'b0}}, ar}) + {{(W+1){1'b0}}, d};
            if (|mac[W+6:W]) begin
               acc_in = WORD_MASK;
               ovf_in = 1'b1;
               ph     = rttip_pkg::PH_SPOOL;
            end else begin
               acc_in = mac[W-1:0];
            end
            adv = adv + 2'd1;
         end
         done = 1'b1;
      end

      if (!done && ph == rttip_pkg::PH_SPOOL) begin
         if (d < ar) begin
            adv = adv + 2'd1;
         end else begin
            hit = 1'b1;
         end
         done = 1'b1;
      end

      if (hit) begin
         ph = rttip_pkg::PH_DISCARD;
      end
   end

   // Saturating character count
   always_comb begin
      pos_sum = {1'b0, pos_ff} + {{(OFFSET_BITS-1){1'b0}}, adv};
      pos_in  = pos_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : pos_sum[OFFSET_BITS-1:0];
      phase_in = ph;
      radix_in = ar;
   end

   // Result outputs: end of number, or end of string before any result
   always_comb begin
      emit_o    = (phase_ff != rttip_pkg::PH_DISCARD) && (hit || last_i);
      res_word  = acc_in;
      res_range = ovf_in;
      if (cfg_i.signed_mode) begin
         if (!acc_in[W-1]) begin
            res_word = neg_in ? (~acc_in + {{(W-1){1'b0}}, 1'b1}) : acc_in;
         end else if (neg_in && (acc_in[W-2:0] == '0)) begin
            res_word = acc_in;
         end else begin
            res_word  = LONG_MAX;
            res_range = 1'b1;
         end
      end
      value_o  = VW'(res_word);
      range_o  = res_range;
      offset_o = pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rttip_pkg::PH_LEAD;
         acc_ff   <= '0;
         radix_ff <= '0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         pos_ff   <= '0;
      end else if (fire_i) begin
         if (last_i) begin
            phase_ff <= rttip_pkg::PH_LEAD;
            acc_ff   <= '0;
            radix_ff <= '0;
            neg_ff   <= 1'b0;
            ovf_ff   <= 1'b0;
            pos_ff   <= '0;
         end else begin
            phase_ff <= emit_o ? rttip_pkg::PH_DISCARD : phase_in;
            acc_ff   <= acc_in;
            radix_ff <= radix_in;
            neg_ff   <= neg_in;
            ovf_ff   <= ovf_in;
            pos_ff   <= pos_in;
         end
      end
   end

endmodule

>>> hdl/rttip_result_reg.sv
// Output result register with valid flag; loads a new beat while the old one drains.
`timescale 1ns / 1ps

module rttip_result_reg #(
   parameter int DATA_W = 80
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_i,
   input  logic [DATA_W-1:0] data_i,
   input  logic              take_i,
   output logic              valid_o,
   output logic [DATA_W-1:0] data_o
);

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load_i) begin
         valid_in = 1'b1;
         data_in  = data_i;
      end else if (take_i) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

>>> hdl/radix_text_to_integer_parser.sv
// Top level of the radix text to integer parser: ports, config, input and result stages.
`timescale 1ns / 1ps

// A character beat accepted into the input stage register is parsed from there; its result,
//   if any, is loaded into the result register and shown on rsp_*.
// Throughput: one character per cycle, set by the combinational multiply-add of the
//   accumulator by the active base; the input stage stalls only behind an unread result.
// Reset: synchronous, active high; clears the stage valids, the parse state and the
//   config (radix 0 = auto, signed_mode 0). csr_ready is always high.

module radix_text_to_integer_parser #(
   parameter int WORD_BITS   = 64,
   parameter int OFFSET_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Character stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] char_code
   input  logic                                 req_tlast,   // last
   // Result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [63:0] value, [64] range_error, [64+OFFSET_BITS:65] end_offset, then zero fill
   output logic [((rttip_pkg::VALUE_W+1+OFFSET_BITS+7)/8)*8-1:0] rsp_tdata,
   // Register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rttip_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rttip_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int VW    = rttip_pkg::VALUE_W;
   localparam int RSP_W = ((VW + 1 + OFFSET_BITS + 7) / 8) * 8;

   // Config registers
   rttip_pkg::cfg_type cfg_ff, cfg_in;

   // Input stage: one held character beat
   logic                         in_valid_ff, in_valid_in;
   logic [rttip_pkg::CHAR_W-1:0] char_ff, char_in;
   logic                         last_ff, last_in;

   logic                         emit;
   logic                         proceed;
   logic                         load;
   logic [VW-1:0]                res_value;
   logic                         res_range;
   logic [OFFSET_BITS-1:0]       res_offset;
   logic [RSP_W-1:0]             res_beat;

   assign csr_ready = 1'b1;

   // Take writes at once; radix keeps the whole data word, signed_mode only its low bit
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rttip_pkg::CSR_RADIX:  cfg_in.radix       = csr_data[rttip_pkg::RADIX_W-1:0];
            rttip_pkg::CSR_SIGNED: cfg_in.signed_mode = csr_data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Advance the held beat unless it would produce a result into a full, stalled register
   assign proceed    = in_valid_ff && (!emit || !rsp_tvalid || rsp_tready);
   assign load       = proceed && emit;
   assign req_tready = !in_valid_ff || proceed;

   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      last_in     = last_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         char_in     = req_tdata;
         last_in     = req_tlast;
      end else if (proceed) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   rttip_parse_core #(
      .WORD_BITS   (WORD_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg_i    (cfg_ff),
      .char_i   (char_ff),
      .last_i   (last_ff),
      .fire_i   (proceed),
      .emit_o   (emit),
      .value_o  (res_value),
      .range_o  (res_range),
      .offset_o (res_offset)
   );

   // Pack the result beat, zero fill to whole bytes
   assign res_beat = RSP_W'({res_offset, res_range, res_value});

   rttip_result_reg #(
      .DATA_W (RSP_W)
   ) u_result (
      .clock   (clock),
      .reset   (reset),
      .load_i  (load),
      .data_i  (res_beat),
      .take_i  (rsp_tready),
      .valid_o (rsp_tvalid),
      .data_o  (rsp_tdata)
   );

   // A result is never written over one that still waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while stalled");

   // A held character that cannot advance stays held
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !proceed) |=> (in_valid_ff && $stable(char_ff) && $stable(last_ff)))
      else $error("held character lost while stalled");

   // Saturated results carry all ones below the top bit of the word
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[VW]) |-> (&rsp_tdata[WORD_BITS-2:0]))
      else $error("range error without saturated value");

   // Reset leaves both stages empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && !in_valid_ff))
      else $error("stage valid set after reset");

endmodule

>>> tb/sv/radix_text_to_integer_parser_tb.sv
// Self-checking testbench for the radix text to integer parser.
`timescale 1ns / 1ps

module radix_text_to_integer_parser_tb;
   import rttip_pkg::*;

   localparam int OFS_W       = 12;
   localparam int RSP_W       = ((VALUE_W + 1 + OFS_W + 7) / 8) * 8;
   localparam int SETTINGS_N  = 13;
   localparam int CHUNK_CHARS = 62;   // random characters per base/sign setting
   localparam int DRAIN_CYCLES = 4;   // a little over the accept-to-result latency
   localparam int HOLD_CYCLES = 300;  // long receiver hold-off to back the block up
   localparam int LONG_BLANKS = 4100; // enough leading blanks to saturate the offset

   localparam logic [VALUE_W-1:0] WORD_ONES = {VALUE_W{1'b1}};
   localparam logic [VALUE_W-1:0] LONG_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] LONG_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } char_beat_t;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               range_err;
      logic [OFS_W-1:0]   offset;
   } parsed_number_t;

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Stimulus and scoreboard
   char_beat_t     pending_chars[$];
   char_beat_t     beat_now;
   parsed_number_t expected_numbers[$];
   parsed_number_t rsp_seen;
   parsed_number_t rsp_want;
   int             beats_queued = 0;
   int             beats_accepted = 0;
   int             strings_sent = 0;
   int             results_checked = 0;
   int             fail_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             plan_step = -1;
   logic           hold_rsp = 1'b0;

   // Shadow of the configuration registers
   logic [RADIX_W-1:0] cfg_radix = RADIX_AUTO;
   logic               cfg_signed = 1'b0;

   // Predicted parse state for the string in flight
   phase_type          ps_phase = PH_LEAD;
   logic [VALUE_W-1:0] ps_acc = '0;
   logic [RADIX_W-1:0] ps_base = '0;
   logic               ps_neg = 1'b0;
   logic               ps_ovf = 1'b0;
   logic [OFS_W-1:0]   ps_pos = '0;

   radix_text_to_integer_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] char_code
      .req_tlast  (req_tlast),   // last
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [63:0] value, [64] range_error, [76:65] end_offset, [79:77] zero
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Character classes as the parser sees them
   // ---------------------------------------------------------------------------------------
   function automatic bit char_is_blank(input logic [CHAR_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // Digit weight in base 36, or NOT_DIGIT for anything else
   function automatic logic [RADIX_W-1:0] char_digit(input logic [CHAR_W-1:0] c);
      if ((c >= CH_ZERO) && (c <= CH_NINE)) return c - CH_ZERO;
      if ((c >= CH_LC_A) && (c <= CH_LC_Z)) return c - CH_LC_A + DIGIT_OFS;
      if ((c >= CH_UC_A) && (c <= CH_UC_Z)) return c - CH_UC_A + DIGIT_OFS;
      return NOT_DIGIT;
   endfunction

   // Lower-case prefix letter that goes with base 16, 8 or 2
   function automatic logic [CHAR_W-1:0] base_letter(input logic [RADIX_W-1:0] b);
      if (b == RADIX_HEX) return CH_LC_X;
      if (b == RADIX_OCT) return CH_LC_O;
      return CH_LC_B;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Number predictor
   // ---------------------------------------------------------------------------------------
   task automatic advance_pos();
      if (ps_pos != {OFS_W{1'b1}}) ps_pos++;
   endtask

   // Close the number: apply the sign rules and queue the expected result beat
   task automatic finish_number();
      parsed_number_t r;
      r.range_err = ps_ovf;
      r.offset    = ps_pos;
      if (!cfg_signed) begin
         r.value = ps_acc;
      end else if (ps_acc <= LONG_MAX) begin
         r.value = ps_neg ? -ps_acc : ps_acc;
      end else if (ps_neg && (ps_acc == LONG_MIN)) begin
         r.value = ps_acc;
      end else begin
         r.value     = LONG_MAX;
         r.range_err = 1'b1;
      end
      expected_numbers.push_back(r);
      ps_phase = PH_DISCARD;
   endtask

   // Feed one character; a phase may hand the same character on to the next phase
   task automatic consume_char(input logic [CHAR_W-1:0] c, output bit made);
      bit                 again;
      logic [RADIX_W-1:0] d;
      logic [VALUE_W-1:0] d64;
      logic [VALUE_W-1:0] b64;
      made  = 1'b0;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (ps_phase)
            PH_LEAD: begin
               if (char_is_blank(c)) begin
                  advance_pos();
               end else begin
                  ps_phase = PH_LEAD2;
                  if (cfg_signed && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                     ps_neg = (c == CH_MINUS);
                     advance_pos();
                  end else begin
                     again = 1'b1;
                  end
               end
            end
            PH_LEAD2: begin
               if (char_is_blank(c)) begin
                  advance_pos();
               end else if (cfg_radix == RADIX_AUTO) begin
                  if (c == CH_ZERO) begin
                     advance_pos();
                     ps_phase = PH_AUTO_ZERO;
                  end else begin
                     ps_base  = RADIX_DEC;
                     ps_phase = PH_ZEROS;
                     again    = 1'b1;
                  end
               end else if ((cfg_radix < RADIX_MIN) || (cfg_radix > RADIX_MAX)) begin
                  finish_number();
                  made = 1'b1;
               end else begin
                  ps_base = cfg_radix;
                  if (((ps_base == RADIX_HEX) || (ps_base == RADIX_OCT) ||
                       (ps_base == RADIX_BIN)) && (c == CH_ZERO)) begin
                     advance_pos();
                     ps_phase = PH_EXPL_ZERO;
                  end else begin
                     ps_phase = PH_ZEROS;
                     again    = 1'b1;
                  end
               end
            end
            PH_AUTO_ZERO: begin
               // the prefix letter itself is not counted as consumed
               if ((c | CASE_BIT) == CH_LC_X) begin
                  ps_base  = RADIX_HEX;
                  ps_phase = PH_PREFIX;
               end else if ((c | CASE_BIT) == CH_LC_O) begin
                  ps_base  = RADIX_OCT;
                  ps_phase = PH_PREFIX;
               end else if ((c | CASE_BIT) == CH_LC_B) begin
                  ps_base  = RADIX_BIN;
                  ps_phase = PH_PREFIX;
               end else begin
                  ps_phase = PH_ZERO_RUN;
                  again    = 1'b1;
               end
            end
            PH_ZERO_RUN: begin
               if (c == CH_ZERO) begin
                  advance_pos();
               end else begin
                  ps_phase = PH_ZERO_WS;
                  again    = 1'b1;
               end
            end
            PH_ZERO_WS: begin
               if (char_is_blank(c)) begin
                  advance_pos();
               end else begin
                  finish_number();
                  made = 1'b1;
               end
            end
            PH_EXPL_ZERO: begin
               if ((c | CASE_BIT) == base_letter(ps_base)) begin
                  ps_phase = PH_PREFIX;
               end else begin
                  ps_phase = PH_ZEROS;
                  again    = 1'b1;
               end
            end
            PH_PREFIX: begin
               // a digit after the prefix counts once here and once more as a digit
               if (char_digit(c) < ps_base) begin
                  advance_pos();
                  ps_phase = PH_ZEROS;
                  again    = 1'b1;
               end else begin
                  finish_number();
                  made = 1'b1;
               end
            end
            PH_ZEROS: begin
               if (c == CH_ZERO) begin
                  advance_pos();
               end else begin
                  ps_phase = PH_DIGITS;
                  again    = 1'b1;
               end
            end
            PH_DIGITS: begin
               d = char_digit(c);
               if (d >= ps_base) begin
                  finish_number();
                  made = 1'b1;
               end else begin
                  d64 = d;
                  b64 = ps_base;
                  if (ps_acc > (WORD_ONES - d64) / b64) begin
                     ps_acc   = WORD_ONES;
                     ps_ovf   = 1'b1;
                     ps_phase = PH_SPOOL;
                  end else begin
                     ps_acc = ps_acc * b64 + d64;
                  end
                  advance_pos();
               end
            end
            PH_SPOOL: begin
               // saturated: swallow the rest of the digits
               if (char_digit(c) < ps_base) begin
                  advance_pos();
               end else begin
                  finish_number();
                  made = 1'b1;
               end
            end
            default: begin
               ps_phase = PH_DISCARD;
            end
         endcase
      end
   endtask

   // One accepted character beat; the last one also sees the implied NUL and clears
   task automatic predict_beat(input logic [CHAR_W-1:0] c, input logic last);
      bit made;
      made = 1'b0;
      if (ps_phase != PH_DISCARD) consume_char(c, made);
      if (last && !made && (ps_phase != PH_DISCARD)) consume_char('0, made);
      if (last) begin
         ps_phase = PH_LEAD;
         ps_acc   = '0;
         ps_base  = '0;
         ps_neg   = 1'b0;
         ps_ovf   = 1'b0;
         ps_pos   = '0;
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Input driver: offer the next pending character, hold it until accepted
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_beat(beat_now.code, beat_now.last);
            beats_accepted++;
         end
         // a new beat only goes out once the current one is gone
         if (!req_tvalid || req_tready) begin
            if ((pending_chars.size() > 0) && ($urandom_range(99) >= send_idle_pct)) begin
               beat_now = pending_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= beat_now.code;
               req_tlast  <= beat_now.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result monitor: compare each accepted result beat with the oldest prediction
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen.value     = rsp_tdata[VALUE_W-1:0];
            rsp_seen.range_err = rsp_tdata[VALUE_W];
            rsp_seen.offset    = rsp_tdata[VALUE_W+OFS_W:VALUE_W+1];
            if (expected_numbers.size() == 0) begin
               $display("%0t: unexpected result beat: value %h range %b offset %0d", $time,
                        rsp_seen.value, rsp_seen.range_err, rsp_seen.offset);
               fail_count++;
            end else begin
               rsp_want = expected_numbers.pop_front();
               results_checked++;
               if (rsp_seen !== rsp_want) begin
                  $display("%0t: mismatch: expected value %h range %b offset %0d, got value %h range %b offset %0d",
                           $time, rsp_want.value, rsp_want.range_err, rsp_want.offset,
                           rsp_seen.value, rsp_seen.range_err, rsp_seen.offset);
                  fail_count++;
               end
            end
         end
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Back-pressure burst: hold the result side off while the sender keeps offering
   initial begin
      wait (plan_step == 2);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d results still outstanding", $time, expected_numbers.size());
      $display("radix_text_to_integer_parser_tb failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   task automatic queue_char(input logic [CHAR_W-1:0] c, input logic last);
      pending_chars.push_back({c, last});
      beats_queued++;
      if (last) strings_sent++;
   endtask

   task automatic queue_literal(input string s);
      for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
   endtask

   function automatic logic [CHAR_W-1:0] blank_char();
      return ($urandom_range(5) == 0) ? CH_SPACE : CH_TAB + $urandom_range(4);
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input int d);
      if (d < 10) return CH_ZERO + d;
      return ($urandom_range(1) ? CH_UC_A : CH_LC_A) + d - 10;
   endfunction

   // Build one string: mostly a well-formed number in the current base, some noise
   task automatic queue_number_string();
      logic [CHAR_W-1:0]  text[$];
      logic [CHAR_W-1:0]  digs[$];
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] base;
      int                 pick;
      bit                 prefix;
      bit                 over;
      if ($urandom_range(6) == 0) begin
         repeat ($urandom_range(1, 5)) text.push_back($urandom_range(255));
      end else begin
         repeat ($urandom_range(2)) text.push_back(blank_char());
         pick = $urandom_range(3);
         if (pick == 0) text.push_back(CH_MINUS);
         else if (pick == 1) text.push_back(CH_PLUS);
         if ((pick < 2) && ($urandom_range(7) == 0)) text.push_back(blank_char());

         if (cfg_radix == RADIX_AUTO) begin
            pick   = $urandom_range(3);
            base   = (pick == 0) ? RADIX_DEC : (pick == 1) ? RADIX_HEX :
                     (pick == 2) ? RADIX_OCT : RADIX_BIN;
            prefix = (base != RADIX_DEC);
         end else if ((cfg_radix < RADIX_MIN) || (cfg_radix > RADIX_MAX)) begin
            base   = RADIX_DEC;
            prefix = 1'b0;
         end else begin
            base   = cfg_radix;
            prefix = ((base == RADIX_HEX) || (base == RADIX_OCT) || (base == RADIX_BIN)) &&
                     ($urandom_range(1) == 1);
         end
         if (prefix) begin
            text.push_back(CH_ZERO);
            text.push_back(base_letter(base[RADIX_W-1:0]) ^ ($urandom_range(1) ? CASE_BIT : '0));
         end
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) text.push_back(CH_ZERO);

         // magnitudes: mostly small, plus the edges of the signed and unsigned ranges
         over = 1'b0;
         case ($urandom_range(11))
            0:       mag = '0;
            6:       mag = {$urandom, $urandom};
            7:       mag = LONG_MIN;
            8:       mag = LONG_MAX + $urandom_range(2);
            9:       mag = WORD_ONES;
            10: begin
               mag  = WORD_ONES;
               over = 1'b1;
            end
            11:      mag = $urandom_range(255);
            default: mag = $urandom_range(65535);
         endcase
         // now and then leave the digits out altogether
         if ($urandom_range(15) != 0) begin
            do begin
               digs.push_front(digit_char(mag % base));
               mag = mag / base;
            end while (mag != 0);
            if (over) digs.push_back(digit_char($urandom_range(base - 1)));
            foreach (digs[i]) text.push_back(digs[i]);
         end

         pick = $urandom_range(3);
         if (pick >= 2) text.push_back($urandom_range(255));
         if (pick == 3) repeat ($urandom_range(1, 3)) text.push_back($urandom_range(255));
      end
      foreach (text[i]) queue_char(text[i], i == text.size() - 1);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_RADIX) cfg_radix = data;
      else cfg_signed = data[0];
      csr_valid <= 1'b0;
   endtask

   // Wait for every queued beat to go in and every predicted result to come out
   task automatic drain();
      while ((beats_accepted != beats_queued) || (expected_numbers.size() != 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [RADIX_W-1:0] r;
      logic               sg;
      int                 chunk_start;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      drain();

      // Directed: auto base with signs, prefixes, bare zero, odd bytes
      write_csr(CSR_RADIX, RADIX_AUTO);
      write_csr(CSR_SIGNED, 6'd1);
      queue_literal(" -0x");       // prefix with no digit behind it
      queue_literal("+0B1");       // upper-case binary prefix
      queue_literal("00\t9");      // bare zero, then blanks, then a stray digit
      queue_literal("-0o7z");      // octal ended by a non-digit
      queue_char(8'hFF, 1'b1);     // top byte alone
      queue_char(8'h00, 1'b0);     // NUL ends the number, the rest is dropped
      queue_char(CH_ZERO + 5, 1'b1);
      queue_literal("Q");          // no digits at all
      drain();
      write_csr(CSR_RADIX, 6'd1);  // base 1 is invalid
      queue_literal(" 7");
      drain();

      // Random: step through base/sign settings and idling patterns
      for (int s = 0; s < SETTINGS_N; s++) begin
         case (s)
            0:       begin r = RADIX_AUTO; sg = 1'b0; end
            1:       begin r = RADIX_AUTO; sg = 1'b1; end
            2:       begin r = RADIX_DEC;  sg = 1'b1; end
            3:       begin r = RADIX_HEX;  sg = 1'b0; end
            4:       begin r = RADIX_HEX;  sg = 1'b1; end
            5:       begin r = RADIX_OCT;  sg = 1'b0; end
            6:       begin r = RADIX_BIN;  sg = 1'b1; end
            7:       begin r = RADIX_MAX;  sg = 1'b0; end
            8:       begin r = RADIX_MAX;  sg = 1'b1; end
            9:       begin r = 6'd1;       sg = 1'b0; end
            10:      begin r = 6'd63;      sg = 1'b1; end
            11:      begin r = RADIX_DEC;  sg = 1'b0; end
            default: begin r = 6'd37;      sg = 1'b0; end
         endcase
         write_csr(CSR_RADIX, r);
         write_csr(CSR_SIGNED, {5'd0, sg});
         case (s % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         plan_step = s;
         // one very long run of blanks to push the offset into saturation
         if (s == 0) begin
            repeat (LONG_BLANKS) queue_char(CH_SPACE, 1'b0);
            queue_char(CH_ZERO + 7, 1'b1);
         end
         chunk_start = beats_queued;
         while (beats_queued - chunk_start < CHUNK_CHARS) queue_number_string();
         drain();
      end

      $display("Covered %0d strings (%0d characters) over %0d base/sign settings and four idling patterns,",
               strings_sent, beats_queued, SETTINGS_N);
      $display("including a long result-side hold-off; %0d results checked, %0d mismatches.",
               results_checked, fail_count);
      if (fail_count == 0) begin
         $display("radix_text_to_integer_parser_tb passed");
      end else begin
         $display("radix_text_to_integer_parser_tb failed");
      end
      $finish;
   end

endmodule
